FILE: sv/mwml_pkg.sv
// ----------------------------------------------------------------------------
// mwml_pkg
// shared widths, register codes and pipeline word types of the wheel mixer
// ----------------------------------------------------------------------------
package mwml_pkg;

  localparam int unsigned CmdW      = 15;
  localparam int unsigned WheelW    = CmdW + 2;      // exact sum of three commands
  localparam int unsigned MagW      = WheelW - 1;    // magnitude of a wheel sum
  localparam int unsigned LimitW    = 15;
  localparam int unsigned OutW      = 16;
  localparam int unsigned ProdW     = MagW + LimitW; // magnitude times limit
  localparam int unsigned QuotW     = LimitW;        // quotient never exceeds the limit
  localparam int unsigned Wheels    = 4;
  localparam int unsigned DivStages = QuotW;         // one quotient bit per stage
  localparam int unsigned PaddrW    = 3;
  localparam int unsigned PdataW    = 32;

  localparam logic [LimitW-1:0] LimitReset = '1;

  // register index, taken from paddr[2]
  typedef enum logic [0:0] {
    REG_SPEED_LIMIT = 1'b0
  } reg_idx_e;

  // word carried through the divider stages
  typedef struct packed {
    logic [Wheels-1:0][ProdW-1:0]  acc;     // partial remainder and quotient bits
    logic [Wheels-1:0][WheelW-1:0] wheel;   // unscaled wheel sums
    logic [MagW-1:0]               divisor; // largest wheel magnitude
    logic                          scaled;
  } div_t;

endpackage

FILE: sv/mwml_if.sv
// ----------------------------------------------------------------------------
// mwml_cmd_if / mwml_res_if
// valid/ready channels for command words and wheel result words
// ----------------------------------------------------------------------------
interface mwml_cmd_if;
  import mwml_pkg::*;

  logic                   valid;
  logic                   ready;
  logic signed [CmdW-1:0] forward_cmd;
  logic signed [CmdW-1:0] lateral_cmd;
  logic signed [CmdW-1:0] rotate_cmd;

  modport source (output valid, output forward_cmd, output lateral_cmd,
                  output rotate_cmd, input ready);
  modport sink   (input valid, input forward_cmd, input lateral_cmd,
                  input rotate_cmd, output ready);
endinterface

interface mwml_res_if;
  import mwml_pkg::*;

  logic                   valid;
  logic                   ready;
  logic signed [OutW-1:0] speed_front_left;
  logic signed [OutW-1:0] speed_front_right;
  logic signed [OutW-1:0] speed_back_right;
  logic signed [OutW-1:0] speed_back_left;
  logic                   was_scaled;

  modport source (output valid, output speed_front_left, output speed_front_right,
                  output speed_back_right, output speed_back_left,
                  output was_scaled, input ready);
  modport sink   (input valid, input speed_front_left, input speed_front_right,
                  input speed_back_right, input speed_back_left,
                  input was_scaled, output ready);
endinterface

FILE: sv/mwml_div_stage.sv
// ----------------------------------------------------------------------------
// mwml_div_stage
// one restoring division step for all four wheels, with its own handshake
// ----------------------------------------------------------------------------
module mwml_div_stage (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  mwml_pkg::div_t in_word_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  output mwml_pkg::div_t out_word_o,
  input  logic          out_ready_i
);
  import mwml_pkg::*;

  logic                      valid_q;
  div_t                      word_q;
  div_t                      word_d;
  logic                      en;
  logic [Wheels-1:0][MagW:0] trial;

  assign en          = !valid_q || out_ready_i;
  assign in_ready_o  = en;
  assign out_valid_o = valid_q;
  assign out_word_o  = word_q;

  // shift in the next dividend bit, subtract the divisor where it fits
  always_comb begin
    word_d = in_word_i;
    for (int i = 0; i < Wheels; i++) begin
      trial[i] = in_word_i.acc[i][ProdW-1:QuotW-1];
      if (trial[i] >= {1'b0, in_word_i.divisor}) begin
        word_d.acc[i] = {MagW'(trial[i] - {1'b0, in_word_i.divisor}),
                         in_word_i.acc[i][QuotW-2:0], 1'b1};
      end else begin
        word_d.acc[i] = {trial[i][MagW-1:0], in_word_i.acc[i][QuotW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && in_valid_i) begin
      word_q <= word_d;
    end
  end

endmodule

FILE: sv/mecanum_wheel_mix_limit_top.sv
// ----------------------------------------------------------------------------
// mecanum_wheel_mix_limit_top
// mecanum wheel mixer with proportional speed limiting
// ----------------------------------------------------------------------------
// cmd_i carries one command word (forward, lateral, rotate) per handshake;
// res_o returns one word per command with the four wheel targets and a flag
// that is set when the largest wheel magnitude exceeded speed_limit and all
// wheels were scaled by speed_limit/max (exact, truncated toward zero).
// speed_limit sits at byte address 0 of the APB-style port; pready is always
// high and the register should be written only while no word is in flight.
// The datapath is a 20-stage pipeline: mix, magnitude, pairwise maximum,
// multiply, fifteen restoring division steps (one quotient bit each) and the
// output register. One word per cycle is sustained while the receiver keeps
// res_o.ready high; the division steps set the depth. Each stage has its own
// valid bit and advances when the stage after it is empty or moving, so a
// stalled receiver only backs up the pipeline as far as it is full and
// bubbles are squeezed out; nothing is lost or repeated. Reset clears every
// valid bit and loads speed_limit with 32767.
// ----------------------------------------------------------------------------
module mecanum_wheel_mix_limit_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  mwml_cmd_if.sink                      cmd_i,
  mwml_res_if.source                    res_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [mwml_pkg::PaddrW-1:0]   paddr,
  input  logic [mwml_pkg::PdataW-1:0]   pwdata,
  output logic [mwml_pkg::PdataW-1:0]   prdata,
  output logic                          pready
);
  import mwml_pkg::*;

  // configuration register
  logic [LimitW-1:0] limit_q;
  reg_idx_e          reg_idx;

  // stage 1: mixed wheel sums
  logic                                 v1_q;
  logic signed [Wheels-1:0][WheelW-1:0] wheel1_q, wheel1_d;
  // stage 2: magnitudes
  logic                                 v2_q;
  logic signed [Wheels-1:0][WheelW-1:0] wheel2_q;
  logic        [Wheels-1:0][MagW-1:0]   mag2_q, mag2_d;
  // stage 3: pairwise maxima
  logic                                 v3_q;
  logic signed [Wheels-1:0][WheelW-1:0] wheel3_q;
  logic        [Wheels-1:0][MagW-1:0]   mag3_q;
  logic        [MagW-1:0]               maxa3_q, maxa3_d, maxb3_q, maxb3_d;
  // stage 4: overall maximum, limit compare, products
  logic                                 v4_q;
  logic signed [Wheels-1:0][WheelW-1:0] wheel4_q;
  logic        [Wheels-1:0][ProdW-1:0]  prod4_q, prod4_d;
  logic        [MagW-1:0]               max4_q, max4_d;
  logic                                 scaled4_q, scaled4_d;
  // output register
  logic                                 out_v_q;
  logic signed [Wheels-1:0][OutW-1:0]   speed_q, speed_d;
  logic                                 scaled_q;

  // stage enables
  logic en1, en2, en3, en4, en_out;

  // division chain, element k feeds stage k
  logic  div_valid [DivStages+1];
  div_t  div_word  [DivStages+1];
  logic  div_ready [DivStages+1];

  // --------------------------------------------------------------------------
  // configuration port
  // --------------------------------------------------------------------------
  assign pready  = 1'b1;
  assign reg_idx = reg_idx_e'(paddr[2]);

  always_comb begin
    unique case (reg_idx)
      REG_SPEED_LIMIT: prdata = PdataW'(limit_q);
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LimitReset;
    end else if (psel && penable && pwrite && pready && reg_idx == REG_SPEED_LIMIT) begin
      limit_q <= pwdata[LimitW-1:0];
    end
  end

  // --------------------------------------------------------------------------
  // flow control: a stage moves when it is empty or its successor moves
  // --------------------------------------------------------------------------
  assign en_out      = !out_v_q || res_o.ready;
  assign en4         = !v4_q || div_ready[0];
  assign en3         = !v3_q || en4;
  assign en2         = !v2_q || en3;
  assign en1         = !v1_q || en2;
  assign cmd_i.ready = en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      v3_q    <= 1'b0;
      v4_q    <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (en1)    v1_q    <= cmd_i.valid;
      if (en2)    v2_q    <= v1_q;
      if (en3)    v3_q    <= v2_q;
      if (en4)    v4_q    <= v3_q;
      if (en_out) out_v_q <= div_valid[DivStages];
    end
  end

  // --------------------------------------------------------------------------
  // stage 1: mecanum mix, exact in 17 bits
  // --------------------------------------------------------------------------
  always_comb begin
    logic signed [WheelW-1:0] vx, vy, wz;
    vx = WheelW'(cmd_i.forward_cmd);
    vy = WheelW'(cmd_i.lateral_cmd);
    wz = WheelW'(cmd_i.rotate_cmd);
    wheel1_d[0] =  vx - vy + wz;   // front left
    wheel1_d[1] =  vx + vy + wz;   // front right
    wheel1_d[2] = -vx + vy + wz;   // back right
    wheel1_d[3] = -vx - vy + wz;   // back left
  end

  always_ff @(posedge clk_i) begin
    if (en1 && cmd_i.valid) begin
      wheel1_q <= wheel1_d;
    end
  end

  // --------------------------------------------------------------------------
  // stage 2: magnitudes (largest is 49152, fits 16 bits unsigned)
  // --------------------------------------------------------------------------
  always_comb begin
    for (int i = 0; i < Wheels; i++) begin
      mag2_d[i] = wheel1_q[i][WheelW-1] ? MagW'(-wheel1_q[i]) : MagW'(wheel1_q[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en2 && v1_q) begin
      wheel2_q <= wheel1_q;
      mag2_q   <= mag2_d;
    end
  end

  // --------------------------------------------------------------------------
  // stage 3: first level of the maximum tree
  // --------------------------------------------------------------------------
  assign maxa3_d = (mag2_q[0] > mag2_q[1]) ? mag2_q[0] : mag2_q[1];
  assign maxb3_d = (mag2_q[2] > mag2_q[3]) ? mag2_q[2] : mag2_q[3];

  always_ff @(posedge clk_i) begin
    if (en3 && v2_q) begin
      wheel3_q <= wheel2_q;
      mag3_q   <= mag2_q;
      maxa3_q  <= maxa3_d;
      maxb3_q  <= maxb3_d;
    end
  end

  // --------------------------------------------------------------------------
  // stage 4: maximum, limit compare and |wheel| * limit
  // --------------------------------------------------------------------------
  assign max4_d    = (maxa3_q > maxb3_q) ? maxa3_q : maxb3_q;
  assign scaled4_d = max4_d > MagW'(limit_q);

  always_comb begin
    for (int i = 0; i < Wheels; i++) begin
      prod4_d[i] = ProdW'(mag3_q[i]) * ProdW'(limit_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en4 && v3_q) begin
      wheel4_q  <= wheel3_q;
      prod4_q   <= prod4_d;
      max4_q    <= max4_d;
      scaled4_q <= scaled4_d;
    end
  end

  // --------------------------------------------------------------------------
  // division: product / max, one quotient bit per stage; the product is
  // below max * 2^15 so the upper half starts under the divisor
  // --------------------------------------------------------------------------
  assign div_valid[0]         = v4_q;
  assign div_word[0].acc      = prod4_q;
  assign div_word[0].wheel    = wheel4_q;
  assign div_word[0].divisor  = max4_q;
  assign div_word[0].scaled   = scaled4_q;
  assign div_ready[DivStages] = en_out;

  for (genvar k = 0; k < DivStages; k++) begin : g_div
    mwml_div_stage u_stage (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .in_valid_i  (div_valid[k]),
      .in_word_i   (div_word[k]),
      .in_ready_o  (div_ready[k]),
      .out_valid_o (div_valid[k+1]),
      .out_word_o  (div_word[k+1]),
      .out_ready_i (div_ready[k+1])
    );
  end

  // --------------------------------------------------------------------------
  // output: restore the sign, or pass the wheel through when not scaled
  // (unscaled wheels are within the limit and fit 16 bits)
  // --------------------------------------------------------------------------
  always_comb begin
    logic [OutW-1:0] quot;
    for (int i = 0; i < Wheels; i++) begin
      quot = OutW'(div_word[DivStages].acc[i][QuotW-1:0]);
      if (div_word[DivStages].scaled) begin
        speed_d[i] = div_word[DivStages].wheel[i][WheelW-1] ? -quot : quot;
      end else begin
        speed_d[i] = div_word[DivStages].wheel[i][OutW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_out && div_valid[DivStages]) begin
      speed_q  <= speed_d;
      scaled_q <= div_word[DivStages].scaled;
    end
  end

  assign res_o.valid             = out_v_q;
  assign res_o.speed_front_left  = speed_q[0];
  assign res_o.speed_front_right = speed_q[1];
  assign res_o.speed_back_right  = speed_q[2];
  assign res_o.speed_back_left   = speed_q[3];
  assign res_o.was_scaled        = scaled_q;

endmodule

FILE: sv/mwml_checker.sv
// ----------------------------------------------------------------------------
// mwml_checker
// port-level checks of the wheel mixer, bound to the top level
// ----------------------------------------------------------------------------
module mwml_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        cmd_valid_i,
  input logic                        cmd_ready_i,
  input logic                        res_valid_i,
  input logic                        res_ready_i,
  input logic [mwml_pkg::OutW-1:0]   speed_fl_i,
  input logic [mwml_pkg::OutW-1:0]   speed_fr_i,
  input logic [mwml_pkg::OutW-1:0]   speed_br_i,
  input logic [mwml_pkg::OutW-1:0]   speed_bl_i,
  input logic                        was_scaled_i,
  input logic                        psel_i,
  input logic                        penable_i,
  input logic                        pwrite_i,
  input logic [mwml_pkg::PaddrW-1:0] paddr_i,
  input logic [mwml_pkg::PdataW-1:0] pwdata_i,
  input logic [mwml_pkg::PdataW-1:0] prdata_i,
  input logic                        pready_i
);
  import mwml_pkg::*;

  localparam int unsigned CntW = $clog2(DivStages + 8);

  logic [CntW-1:0] inflight_q;
  logic            cmd_take, res_take, limit_wr, limit_rd;
  logic [OutW:0]   sum_a, sum_b;

  assign cmd_take = cmd_valid_i && cmd_ready_i;
  assign res_take = res_valid_i && res_ready_i;
  assign limit_wr = psel_i && penable_i && pwrite_i && pready_i && !paddr_i[2];
  assign limit_rd = psel_i && !pwrite_i && !paddr_i[2];

  // front left + back right and front right + back left both equal 2*rotate
  assign sum_a = {speed_fl_i[OutW-1], speed_fl_i} + {speed_br_i[OutW-1], speed_br_i};
  assign sum_b = {speed_fr_i[OutW-1], speed_fr_i} + {speed_bl_i[OutW-1], speed_bl_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inflight_q <= '0;
    end else if (cmd_take && !res_take) begin
      inflight_q <= inflight_q + 1'b1;
    end else if (res_take && !cmd_take) begin
      inflight_q <= inflight_q - 1'b1;
    end
  end

  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i && $stable(speed_fl_i)
      && $stable(speed_fr_i) && $stable(speed_br_i) && $stable(speed_bl_i)
      && $stable(was_scaled_i))
    else $error("result word changed while stalled");

  a_no_orphan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i |-> inflight_q != '0)
    else $error("result word without a command word in flight");

  a_unscaled_mix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !was_scaled_i |-> sum_a == sum_b)
    else $error("unscaled wheel targets break the mix identity");

  a_readback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    limit_wr ##1 limit_rd |-> prdata_i[LimitW-1:0] == $past(pwdata_i[LimitW-1:0]))
    else $error("speed limit readback differs from the written value");

endmodule

bind mecanum_wheel_mix_limit_top mwml_checker u_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .cmd_valid_i  (cmd_i.valid),
  .cmd_ready_i  (cmd_i.ready),
  .res_valid_i  (res_o.valid),
  .res_ready_i  (res_o.ready),
  .speed_fl_i   (res_o.speed_front_left),
  .speed_fr_i   (res_o.speed_front_right),
  .speed_br_i   (res_o.speed_back_right),
  .speed_bl_i   (res_o.speed_back_left),
  .was_scaled_i (res_o.was_scaled),
  .psel_i       (psel),
  .penable_i    (penable),
  .pwrite_i     (pwrite),
  .paddr_i      (paddr),
  .pwdata_i     (pwdata),
  .prdata_i     (prdata),
  .pready_i     (pready)
);
